### rtl/v4alu_pkg.sv
// Shared opcodes, types and the saturation helper of the four-lane vector ALU.
package v4alu_pkg;

  localparam int LANES = 4;
  localparam int DW    = 32;

  localparam logic [4:0] OP_ADD  = 5'd0;
  localparam logic [4:0] OP_SUB  = 5'd1;
  localparam logic [4:0] OP_MUL  = 5'd2;
  localparam logic [4:0] OP_DIV  = 5'd3;
  localparam logic [4:0] OP_MIN  = 5'd4;
  localparam logic [4:0] OP_MAX  = 5'd5;
  localparam logic [4:0] OP_ABS  = 5'd6;
  localparam logic [4:0] OP_SIGN = 5'd7;
  localparam logic [4:0] OP_NEG  = 5'd8;
  localparam logic [4:0] OP_SADD = 5'd9;
  localparam logic [4:0] OP_SSUB = 5'd10;
  localparam logic [4:0] OP_SMUL = 5'd11;
  localparam logic [4:0] OP_SDIV = 5'd12;
  localparam logic [4:0] OP_DOT  = 5'd13;
  localparam logic [4:0] OP_LEN  = 5'd14;
  localparam logic [4:0] OP_NORM = 5'd15;
  localparam logic [4:0] OP_EQ   = 5'd16;

  typedef logic signed [DW-1:0] word_t;

  localparam word_t WMAX = 32'sh7FFFFFFF;
  localparam word_t WMIN = 32'sh80000000;
  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

  // Operands and partial results carried along the front of the pipeline.
  typedef struct packed {
    logic [4:0]              op;
    word_t [LANES-1:0]       a;
    word_t [LANES-1:0]       b;
    word_t                   s;
    word_t [LANES-1:0]       rs;
    word_t                   so;
    logic                    eq;
  } side_a_t;

  // What the divider stages need besides the quotients.
  typedef struct packed {
    logic [4:0]              op;
    word_t [LANES-1:0]       rs;
    word_t                   so;
    logic                    eq;
    logic [LANES-1:0]        neg;
    logic [LANES-1:0]        zero;
  } side_b_t;

  typedef struct packed {
    logic                    eq;
    word_t                   so;
    word_t [LANES-1:0]       r;
  } out_t;

  function automatic word_t sat32(input logic signed [65:0] v);
    word_t res;
    if (v > SAT_HI) begin
      res = WMAX;
    end else if (v < SAT_LO) begin
      res = WMIN;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

### rtl/v4alu_sqrt.sv
// Pipelined floor square root of a 65-bit value, one root bit per stage.
module v4alu_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [64:0] n_in,
  output logic [32:0] root
);

  localparam int STAGES = 33;

  logic [34:0] rem_q  [STAGES-1];
  logic [65:0] n_q    [STAGES-1];
  logic [32:0] root_q [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_st
    logic [34:0] rem_p;
    logic [32:0] root_p;
    logic [65:0] n_p;
    logic [36:0] rem_t;
    logic [36:0] trial;
    logic        take;

    if (i == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign n_p    = {1'b0, n_in};
    end else begin : g_next
      assign rem_p  = rem_q[i-1];
      assign root_p = root_q[i-1];
      assign n_p    = n_q[i-1];
    end

    // Bring down the next two bits and try the digit one.
    assign rem_t = {rem_p, n_p[65:64]};
    assign trial = {2'b00, root_p, 2'b01};
    assign take  = (rem_t >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        root_q[i] <= {root_p[31:0], take};
      end
    end

    if (i < STAGES - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[i] <= take ? 35'(rem_t - trial) : rem_t[34:0];
          n_q[i]   <= {n_p[63:0], 2'b00};
        end
      end
    end
  end

  assign root = root_q[STAGES-1];

endmodule

### rtl/v4alu_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module v4alu_div #(
  parameter int ND = 48
) (
  input  logic          clk,
  input  logic          en,
  input  logic [ND-1:0] num,
  input  logic [32:0]   den,
  output logic [ND-1:0] quo
);

  logic [32:0]   rem_q [ND-1];
  logic [32:0]   den_q [ND-1];
  logic [ND-1:0] qn_q  [ND];

  for (genvar i = 0; i < ND; i++) begin : g_st
    logic [32:0]   rem_p;
    logic [32:0]   den_p;
    logic [ND-1:0] qn_p;
    logic [33:0]   rem_t;
    logic          take;

    if (i == 0) begin : g_first
      assign rem_p = '0;
      assign den_p = den;
      assign qn_p  = num;
    end else begin : g_next
      assign rem_p = rem_q[i-1];
      assign den_p = den_q[i-1];
      assign qn_p  = qn_q[i-1];
    end

    // Dividend bits shift out at the top while quotient bits shift in below.
    assign rem_t = {rem_p, qn_p[ND-1]};
    assign take  = (rem_t >= {1'b0, den_p});

    always_ff @(posedge clk) begin
      if (en) begin
        qn_q[i] <= {qn_p[ND-2:0], take};
      end
    end

    if (i < ND - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[i] <= take ? 33'(rem_t - {1'b0, den_p}) : rem_t[32:0];
          den_q[i] <= den_p;
        end
      end
    end
  end

  assign quo = qn_q[ND-1];

endmodule

### rtl/vec4_alu.sv
// Four-lane fixed point vector ALU, top level.
//
// One operation goes in per transfer on the s_ channel: an opcode, two
// four-lane vectors and a scalar, all signed fixed point with FRAC_BITS
// fraction bits. One result comes out per operation on the m_ channel: a
// vector, a scalar and an equality flag, in the order the inputs came.
// Every opcode runs through the same pipeline. The depth is set by the
// square root stages (33, one root bit each) followed by the lane dividers
// (32 + FRAC_BITS stages, one quotient bit each), which normalize needs in
// that order. A new operation is taken in every cycle while s_tready is
// high. The result side ends in a two-entry buffer; the pipeline keeps
// moving while one result waits and holds as a whole only when both entries
// are full and m_tready is low, which drops s_tready in the same cycle.
// Nothing is lost or repeated. Reset clears all valid bits and the buffer;
// no operation is in flight afterwards.
module vec4_alu #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in, zero pad
  input  logic [295:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // r_x, r_y, r_z, r_w, scalar_out, equal_flag, zero pad
  output logic [167:0] m_tdata
);

  localparam int LN        = v4alu_pkg::LANES;
  localparam int ND        = v4alu_pkg::DW + FRAC_BITS;
  localparam int SQ_STAGES = 33;

  localparam v4alu_pkg::word_t  ONE_FX = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] BIAS  = (64'sd1 <<< FRAC_BITS) - 64'sd1;
  localparam logic [ND-1:0] Q_POS_MAX  = ND'(64'h7FFFFFFF);
  localparam logic [ND-1:0] Q_NEG_MAX  = ND'(64'h80000000);

  logic en;
  logic [1:0] cnt;

  assign en       = (cnt != 2'd2) || m_tready;
  assign s_tready = en;

  // Input register.
  logic                              v1;
  logic [4:0]                        op1;
  v4alu_pkg::word_t [LN-1:0]         a1;
  v4alu_pkg::word_t [LN-1:0]         b1;
  v4alu_pkg::word_t                  s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1 <= s_tdata[4:0];
      for (int k = 0; k < LN; k++) begin
        a1[k] <= s_tdata[5 + 32*k +: 32];
        b1[k] <= s_tdata[133 + 32*k +: 32];
      end
      s1 <= s_tdata[292:261];
    end
  end

  // Multiply stage; the simple lane operations finish here as well.
  logic                       v2;
  v4alu_pkg::side_a_t         st2;
  logic signed [63:0]         prod2 [LN];
  v4alu_pkg::word_t [LN-1:0]  mop;
  v4alu_pkg::word_t [LN-1:0]  rs_d;
  logic                       eq_d;

  always_comb begin
    logic signed [32:0] ea;
    logic signed [32:0] eb;
    logic signed [32:0] es;
    for (int k = 0; k < LN; k++) begin
      ea = {a1[k][31], a1[k]};
      eb = {b1[k][31], b1[k]};
      es = {s1[31], s1};
      if (op1 == v4alu_pkg::OP_LEN || op1 == v4alu_pkg::OP_NORM) begin
        mop[k] = a1[k];
      end else if (op1 == v4alu_pkg::OP_SMUL) begin
        mop[k] = s1;
      end else begin
        mop[k] = b1[k];
      end
      case (op1)
        v4alu_pkg::OP_ADD:  rs_d[k] = v4alu_pkg::sat32(66'(ea + eb));
        v4alu_pkg::OP_SUB:  rs_d[k] = v4alu_pkg::sat32(66'(ea - eb));
        v4alu_pkg::OP_MIN:  rs_d[k] = ($signed(a1[k]) < $signed(b1[k])) ? a1[k] : b1[k];
        v4alu_pkg::OP_MAX:  rs_d[k] = ($signed(a1[k]) > $signed(b1[k])) ? a1[k] : b1[k];
        v4alu_pkg::OP_ABS:  rs_d[k] = a1[k][31] ? v4alu_pkg::sat32(66'(-ea)) : a1[k];
        v4alu_pkg::OP_SIGN: begin
          if (a1[k][31]) begin
            rs_d[k] = -ONE_FX;
          end else if (a1[k] != '0) begin
            rs_d[k] = ONE_FX;
          end else begin
            rs_d[k] = '0;
          end
        end
        v4alu_pkg::OP_NEG:  rs_d[k] = v4alu_pkg::sat32(66'(-ea));
        v4alu_pkg::OP_SADD: rs_d[k] = v4alu_pkg::sat32(66'(ea + es));
        v4alu_pkg::OP_SSUB: rs_d[k] = v4alu_pkg::sat32(66'(ea - es));
        default:            rs_d[k] = '0;
      endcase
    end
    eq_d = (op1 == v4alu_pkg::OP_EQ) && (a1 == b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st2.op <= op1;
      st2.a  <= a1;
      st2.b  <= b1;
      st2.s  <= s1;
      st2.rs <= rs_d;
      st2.so <= '0;
      st2.eq <= eq_d;
      for (int k = 0; k < LN; k++) begin
        prod2[k] <= 64'($signed(a1[k]) * $signed(mop[k]));
      end
    end
  end

  // Truncate products toward zero.
  logic                      v3;
  v4alu_pkg::side_a_t        st3;
  logic signed [63:0]        tp3 [LN];
  logic [62:0]               sq3 [LN];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [63:0] tp;
    v4alu_pkg::side_a_t nx;
    if (en) begin
      nx = st2;
      for (int k = 0; k < LN; k++) begin
        tp = (prod2[k] + (prod2[k][63] ? BIAS : 64'sd0)) >>> FRAC_BITS;
        tp3[k] <= tp;
        sq3[k] <= prod2[k][62:0];
        if (st2.op == v4alu_pkg::OP_MUL || st2.op == v4alu_pkg::OP_SMUL) begin
          nx.rs[k] = v4alu_pkg::sat32(66'(tp));
        end
      end
      st3 <= nx;
    end
  end

  // Sums: dot product and sum of squares.
  logic                v4;
  v4alu_pkg::side_a_t  st4;
  logic [64:0]         n4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [65:0] dot;
    v4alu_pkg::side_a_t nx;
    if (en) begin
      dot = 66'(tp3[0]) + 66'(tp3[1]) + 66'(tp3[2]) + 66'(tp3[3]);
      nx    = st3;
      nx.so = (st3.op == v4alu_pkg::OP_DOT) ? v4alu_pkg::sat32(dot) : '0;
      st4   <= nx;
      n4    <= 65'(sq3[0]) + 65'(sq3[1]) + 65'(sq3[2]) + 65'(sq3[3]);
    end
  end

  // Square root, with the rest of the item delayed alongside.
  logic [32:0]          len;
  v4alu_pkg::side_a_t   sa_q [SQ_STAGES];
  logic [SQ_STAGES-1:0] sa_v;

  v4alu_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .n_in (n4),
    .root (len)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_v <= '0;
    end else if (en) begin
      sa_v <= {sa_v[SQ_STAGES-2:0], v4};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_q[0] <= st4;
      for (int i = 1; i < SQ_STAGES; i++) begin
        sa_q[i] <= sa_q[i-1];
      end
    end
  end

  // Divider setup: magnitudes, divisor choice and result sign.
  v4alu_pkg::side_a_t sx;
  logic [ND-1:0]      num_d [LN];
  logic [32:0]        den_d [LN];
  logic [LN-1:0]      neg_d;
  logic [LN-1:0]      zero_d;

  assign sx = sa_q[SQ_STAGES-1];

  always_comb begin
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] mag_s;
    logic        dneg;
    for (int k = 0; k < LN; k++) begin
      mag_a = sx.a[k][31] ? 32'(-sx.a[k]) : 32'(sx.a[k]);
      mag_b = sx.b[k][31] ? 32'(-sx.b[k]) : 32'(sx.b[k]);
      mag_s = sx.s[31]    ? 32'(-sx.s)    : 32'(sx.s);
      num_d[k] = {mag_a, {FRAC_BITS{1'b0}}};
      if (sx.op == v4alu_pkg::OP_NORM) begin
        den_d[k] = len;
        dneg     = 1'b0;
      end else if (sx.op == v4alu_pkg::OP_SDIV) begin
        den_d[k] = {1'b0, mag_s};
        dneg     = sx.s[31];
      end else begin
        den_d[k] = {1'b0, mag_b};
        dneg     = sx.b[k][31];
      end
      neg_d[k]  = sx.a[k][31] ^ dneg;
      zero_d[k] = (den_d[k] == '0);
    end
  end

  logic                v5;
  v4alu_pkg::side_b_t  sb5;
  logic [ND-1:0]       num5 [LN];
  logic [32:0]         den5 [LN];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= sa_v[SQ_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb5.op   <= sx.op;
      sb5.rs   <= sx.rs;
      sb5.eq   <= sx.eq;
      sb5.neg  <= neg_d;
      sb5.zero <= zero_d;
      if (sx.op == v4alu_pkg::OP_LEN) begin
        sb5.so <= (len > 33'd2147483647) ? v4alu_pkg::WMAX : len[31:0];
      end else begin
        sb5.so <= sx.so;
      end
      for (int k = 0; k < LN; k++) begin
        num5[k] <= num_d[k];
        den5[k] <= den_d[k];
      end
    end
  end

  // Lane dividers.
  logic [ND-1:0]      quo [LN];
  v4alu_pkg::side_b_t sb_q [ND];
  logic [ND-1:0]      sb_v;

  for (genvar k = 0; k < LN; k++) begin : g_lane
    v4alu_div #(
      .ND (ND)
    ) u_div (
      .clk (clk),
      .en  (en),
      .num (num5[k]),
      .den (den5[k]),
      .quo (quo[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_v <= '0;
    end else if (en) begin
      sb_v <= {sb_v[ND-2:0], v5};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_q[0] <= sb5;
      for (int i = 1; i < ND; i++) begin
        sb_q[i] <= sb_q[i-1];
      end
    end
  end

  // Final selection and saturation of the quotients.
  v4alu_pkg::side_b_t sy;
  v4alu_pkg::out_t    out_d;

  assign sy = sb_q[ND-1];

  always_comb begin
    out_d.eq = sy.eq;
    out_d.so = sy.so;
    for (int k = 0; k < LN; k++) begin
      if (sy.op == v4alu_pkg::OP_DIV || sy.op == v4alu_pkg::OP_SDIV ||
          sy.op == v4alu_pkg::OP_NORM) begin
        if (sy.zero[k]) begin
          out_d.r[k] = '0;
        end else if (sy.neg[k]) begin
          out_d.r[k] = (quo[k] > Q_NEG_MAX) ? v4alu_pkg::WMIN : 32'(-quo[k][31:0]);
        end else begin
          out_d.r[k] = (quo[k] > Q_POS_MAX) ? v4alu_pkg::WMAX : quo[k][31:0];
        end
      end else begin
        out_d.r[k] = sy.rs[k];
      end
    end
  end

  // Two-entry result buffer.
  v4alu_pkg::out_t fifo [2];
  logic            wptr;
  logic            rptr;
  logic            push;
  logic            pop;

  assign push     = en && sb_v[ND-1];
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = {7'b0, fifo[rptr]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= 2'd0;
      wptr <= 1'b0;
      rptr <= 1'b0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= out_d;
    end
  end

  // A full buffer that is not drained must hold off new input.
  a_full_stall : assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && !m_tready) |-> !s_tready)
    else $error("input taken while result buffer full");

  // The buffer never holds more than two results.
  a_cnt_range : assert property (@(posedge clk) disable iff (rst)
    (cnt != 2'd3))
    else $error("result buffer count out of range");

  // The equality result never comes with a vector or scalar result.
  a_eq_alone : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[160]) |-> (m_tdata[159:0] == '0))
    else $error("equal flag set together with arithmetic result");

  // While stalled, the pipeline valid bits stay put.
  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    (!s_tready) |=> ($stable(v4) && $stable(sa_v) && $stable(sb_v)))
    else $error("pipeline moved during a stall");

endmodule
